// ----- hdl/pbe_pkg.sv -----
package pbe_pkg;

  localparam int MAX_VERTICES_DEF = 64;

  localparam int CW = 32;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t [2:0] point_t;
  typedef point_t [2:0] row_t;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_EVAL  = 2'd2;

  localparam logic [1:0] SLOT_ANCHOR  = 2'd0;
  localparam logic [1:0] SLOT_IN      = 2'd1;
  localparam logic [1:0] SLOT_OUT     = 2'd2;
  localparam logic [1:0] SLOT_INVALID = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

endpackage

// ----- hdl/pbe_store.sv -----
module pbe_store #(
  parameter int MAX_VERTICES = pbe_pkg::MAX_VERTICES_DEF,
  localparam int VW = $clog2(MAX_VERTICES)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [VW-1:0]   wr_vertex_i,
  input  logic [1:0]      wr_slot_i,
  input  pbe_pkg::point_t wr_point_i,
  input  logic [VW-1:0]   rd_vertex_i,
  output pbe_pkg::row_t   rd_lo_o,
  output pbe_pkg::row_t   rd_hi_o
);
  import pbe_pkg::*;

  localparam int BD = (MAX_VERTICES + 1) / 2;
  localparam int AW = (BD > 1) ? $clog2(BD) : 1;

  row_t mem_e [BD];
  row_t mem_o [BD];

  logic [AW-1:0] wa;
  logic [AW-1:0] ra_e;
  logic [AW-1:0] ra_o;
  row_t          rd_e_q;
  row_t          rd_o_q;
  logic          sel_q;

  // even vertices in one bank, odd in the other, so v and v+1 read together
  assign wa   = AW'(wr_vertex_i >> 1);
  assign ra_o = AW'(rd_vertex_i >> 1);
  assign ra_e = AW'(({1'b0, rd_vertex_i} + (VW+1)'(1)) >> 1);

  always_ff @(posedge clk_i) begin
    if (we_i && !wr_vertex_i[0]) begin
      mem_e[wa][wr_slot_i] <= wr_point_i;
    end
    rd_e_q <= mem_e[ra_e];
  end

  always_ff @(posedge clk_i) begin
    if (we_i && wr_vertex_i[0]) begin
      mem_o[wa][wr_slot_i] <= wr_point_i;
    end
    rd_o_q <= mem_o[ra_o];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= rd_vertex_i[0];
    end
  end

  assign rd_lo_o = sel_q ? rd_o_q : rd_e_q;
  assign rd_hi_o = sel_q ? rd_e_q : rd_o_q;

endmodule

// ----- hdl/piecewise_cubic_bezier_evaluator.sv -----
// Evaluates a piecewise cubic Bezier spline held in an on-chip vertex table, and reads or
// writes single points of that table. One command is taken every clock cycle (busy_o stays
// low); each gives exactly one result on done_o five cycles after it is taken, and the
// receiver must take it then. The latency is set by the pipeline behind the one-cycle
// table read: two multiply stages for the basis weights, one for the weighted points and
// one for rounding and saturation. The table is split into even and odd vertex banks, so
// the two vertices of a segment are read in the same cycle. A write lands at the edge
// that takes it, so a following command already sees it.
module piecewise_cubic_bezier_evaluator #(
  parameter int MAX_VERTICES = pbe_pkg::MAX_VERTICES_DEF,
  localparam int VW = $clog2(MAX_VERTICES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         func_i,
  input  logic [5:0]         vertex_index_i,
  input  logic [1:0]         point_slot_i,
  input  logic signed [31:0] in_x_i,
  input  logic signed [31:0] in_y_i,
  input  logic signed [31:0] in_z_i,
  input  logic signed [18:0] curve_time_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         cfg_data_i,
  output logic               done_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [1:0]         status_o
);
  import pbe_pkg::*;

  typedef enum logic [2:0] {
    MODE_ZERO,
    MODE_READ,
    MODE_BEZ,
    MODE_EXT_LO,
    MODE_EXT_HI
  } mode_e;

  logic [6:0] cfg_q;
  logic       acc;
  logic [6:0] n;
  logic [6:0] nm1;
  logic [22:0] p;
  logic [6:0]  seg;
  logic [15:0] u;
  logic        t_mid;
  logic        t_le0;
  logic        bad_rw;
  mode_e       mode;
  logic [1:0]  st;
  logic [VW-1:0] va;
  logic [1:0]  rslot;
  logic        we;
  logic signed [18:0] scale;
  point_t      wr_pt;
  row_t        lo;
  row_t        hi;

  logic        vld1_q, vld2_q, vld3_q, vld4_q, done_q;
  mode_e       m1_q, m2_q, m3_q, m4_q;
  logic [1:0]  st1_q, st2_q, st3_q, st4_q;
  logic [1:0]  rslot1_q;
  logic [15:0] u1_q, u2_q;
  logic [16:0] v1_q, v2_q;
  logic signed [18:0] sc1_q, sc2_q, sc3_q;

  logic [31:0] uu2_q;
  logic [33:0] vv2_q;
  logic [32:0] uv2_q;
  point_t      pa2_q, pb2_q, pc2_q, pd2_q, ea2_q, eb2_q;

  logic [51:0] m0, m1, m2, m3;
  logic [24:0] w0_3q, w1_3q, w2_3q, w3_3q;
  point_t      pa3_q, pb3_q, pc3_q, pd3_q;
  logic signed [34:0] d3_q [3];
  logic signed [34:0] diff [3];

  logic signed [57:0] pr4_q [3][4];
  logic signed [53:0] ep4_q [3];
  point_t             pa4_q;

  logic signed [59:0] bsum [3];
  logic signed [35:0] br [3];
  logic signed [37:0] er [3];
  logic signed [39:0] val [3];
  logic signed [31:0] satv [3];
  logic [2:0]         satf;
  point_t             out_q;
  logic [1:0]         status_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign acc         = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 7'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // command decode
  assign n      = ({25'd0, cfg_q} > MAX_VERTICES) ? 7'(MAX_VERTICES) : cfg_q;
  assign nm1    = n - 7'd1;
  assign p      = {16'd0, nm1} * {7'd0, curve_time_i[15:0]};
  assign seg    = p[22:16];
  assign u      = p[15:0];
  assign t_le0  = curve_time_i[18] || (curve_time_i == 19'sd0);
  assign t_mid  = !t_le0 && (curve_time_i[17:16] == 2'b00);
  assign bad_rw = ({1'b0, vertex_index_i} >= n) || (point_slot_i == SLOT_INVALID);
  assign scale  = t_le0 ? curve_time_i : (19'sd65536 - curve_time_i);
  assign wr_pt  = {in_z_i, in_y_i, in_x_i};

  always_comb begin
    mode  = MODE_ZERO;
    st    = ST_BAD;
    va    = '0;
    rslot = SLOT_ANCHOR;
    we    = 1'b0;
    unique case (func_i)
      FUNC_WRITE: begin
        st = bad_rw ? ST_BAD : ST_OK;
        we = !bad_rw;
      end
      FUNC_READ: begin
        if (!bad_rw) begin
          mode  = MODE_READ;
          st    = ST_OK;
          va    = VW'(vertex_index_i);
          rslot = point_slot_i;
        end
      end
      FUNC_EVAL: begin
        st = ST_OK;
        if (n == 7'd0) begin
          mode = MODE_ZERO;
        end else if (n == 7'd1) begin
          mode = MODE_READ;
        end else if (t_mid) begin
          mode = MODE_BEZ;
          va   = VW'(seg);
        end else if (t_le0) begin
          mode = MODE_EXT_LO;
        end else begin
          mode = MODE_EXT_HI;
          va   = VW'(nm1);
        end
      end
      default: begin
        mode = MODE_ZERO;
        st   = ST_BAD;
      end
    endcase
  end

  pbe_store #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (acc && we),
    .wr_vertex_i (VW'(vertex_index_i)),
    .wr_slot_i   (point_slot_i),
    .wr_point_i  (wr_pt),
    .rd_vertex_i (va),
    .rd_lo_o     (lo),
    .rd_hi_o     (hi)
  );

  // pipeline valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld1_q <= acc;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      done_q <= vld4_q;
    end
  end

  // stage 1: table read, basis squares
  always_ff @(posedge clk_i) begin
    m1_q     <= mode;
    st1_q    <= st;
    rslot1_q <= rslot;
    u1_q     <= u;
    v1_q     <= 17'd65536 - {1'b0, u};
    sc1_q    <= scale;
  end

  always_ff @(posedge clk_i) begin
    m2_q  <= m1_q;
    st2_q <= st1_q;
    u2_q  <= u1_q;
    v2_q  <= v1_q;
    sc2_q <= sc1_q;
    uu2_q <= {16'd0, u1_q} * {16'd0, u1_q};
    vv2_q <= {17'd0, v1_q} * {17'd0, v1_q};
    uv2_q <= {17'd0, u1_q} * {16'd0, v1_q};
    pa2_q <= lo[rslot1_q];
    pb2_q <= lo[SLOT_OUT];
    pc2_q <= hi[SLOT_IN];
    pd2_q <= hi[SLOT_ANCHOR];
    ea2_q <= (m1_q == MODE_EXT_LO) ? lo[SLOT_IN] : lo[SLOT_ANCHOR];
    eb2_q <= (m1_q == MODE_EXT_LO) ? lo[SLOT_ANCHOR] : lo[SLOT_OUT];
  end

  // stage 2: cubic weights rounded to q0.24, end derivative
  assign m0 = 52'(vv2_q) * 52'(v2_q);
  assign m3 = 52'(uu2_q) * 52'(u2_q);
  assign m1 = 52'(uv2_q) * 52'(v2_q);
  assign m2 = 52'(uv2_q) * 52'(u2_q);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = 35'(ea2_q[k]) - 35'(eb2_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    m3_q  <= m2_q;
    st3_q <= st2_q;
    sc3_q <= sc2_q;
    w0_3q <= 25'((m0 + 52'd8388608) >> 24);
    w1_3q <= 25'(((m1 << 1) + m1 + 52'd8388608) >> 24);
    w2_3q <= 25'(((m2 << 1) + m2 + 52'd8388608) >> 24);
    w3_3q <= 25'((m3 + 52'd8388608) >> 24);
    pa3_q <= pa2_q;
    pb3_q <= pb2_q;
    pc3_q <= pc2_q;
    pd3_q <= pd2_q;
    for (int k = 0; k < 3; k++) begin
      d3_q[k] <= (diff[k] <<< 1) + diff[k];
    end
  end

  // stage 3: weighted points
  always_ff @(posedge clk_i) begin
    m4_q  <= m3_q;
    st4_q <= st3_q;
    pa4_q <= pa3_q;
    for (int k = 0; k < 3; k++) begin
      pr4_q[k][0] <= 58'($signed(pa3_q[k]) * $signed({1'b0, w0_3q}));
      pr4_q[k][1] <= 58'($signed(pb3_q[k]) * $signed({1'b0, w1_3q}));
      pr4_q[k][2] <= 58'($signed(pc3_q[k]) * $signed({1'b0, w2_3q}));
      pr4_q[k][3] <= 58'($signed(pd3_q[k]) * $signed({1'b0, w3_3q}));
      ep4_q[k]    <= 54'(d3_q[k] * sc3_q);
    end
  end

  // stage 4: round, add, saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bsum[k] = 60'(pr4_q[k][0]) + 60'(pr4_q[k][1]) + 60'(pr4_q[k][2])
              + 60'(pr4_q[k][3]);
      br[k]   = 36'((bsum[k] + 60'sd8388608) >>> 24);
      er[k]   = 38'((ep4_q[k] + 54'sd32768) >>> 16);
      val[k]  = (m4_q == MODE_BEZ) ? 40'(br[k])
                                   : (40'(er[k]) + 40'($signed(pa4_q[k])));
      if (val[k] > 40'sd2147483647) begin
        satv[k] = 32'sh7fffffff;
        satf[k] = 1'b1;
      end else if (val[k] < -40'sd2147483648) begin
        satv[k] = 32'sh80000000;
        satf[k] = 1'b1;
      end else begin
        satv[k] = 32'(val[k]);
        satf[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (m4_q)
      MODE_READ: begin
        out_q    <= pa4_q;
        status_q <= st4_q;
      end
      MODE_BEZ, MODE_EXT_LO, MODE_EXT_HI: begin
        out_q    <= {satv[2], satv[1], satv[0]};
        status_q <= (satf != 3'b000) ? ST_SAT : ST_OK;
      end
      default: begin
        out_q    <= '0;
        status_q <= st4_q;
      end
    endcase
  end

  assign done_o   = done_q;
  assign out_x_o  = out_q[0];
  assign out_y_o  = out_q[1];
  assign out_z_o  = out_q[2];
  assign status_o = status_q;

`ifndef NO_ASSERTIONS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##5 done_o)
    else $error("command without result");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, 5))
    else $error("result without command");

  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_BAD) |-> (out_x_o == 32'sd0 && out_y_o == 32'sd0
                                        && out_z_o == 32'sd0))
    else $error("rejected command gave nonzero point");
`endif

endmodule
